// ===== rtl/pwmp_pkg.sv =====
`default_nettype none
package pwmp_pkg;

    localparam int MAX_PIECES = 4096;
    localparam int MAP_BYTES  = (MAX_PIECES + 7) / 8;
    localparam int ADDR_W     = $clog2(MAP_BYTES);
    localparam int QDEPTH     = 3;

    localparam logic [1:0] CFG_PIECE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PIECE_SIZE    = 2'd1;
    localparam logic [1:0] CFG_CONTENT_BYTES = 2'd2;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_ID  = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_KEEPALIVE = 4'd0,
        EV_CHOKE     = 4'd1,
        EV_UNCHOKE   = 4'd2,
        EV_INTEREST  = 4'd3,
        EV_NOTINT    = 4'd4,
        EV_HAVE      = 4'd5,
        EV_BITFIELD  = 4'd6,
        EV_REQUEST   = 4'd7,
        EV_PIECEDATA = 4'd8,
        EV_CANCEL    = 4'd9,
        EV_UNKNOWN   = 4'd10,
        EV_ERROR     = 4'd11,
        EV_BF_SIZE   = 4'd12,
        EV_QUERY     = 4'd13
    } ev_t;

    localparam logic [7:0] ID_CHOKE    = 8'd0;
    localparam logic [7:0] ID_UNCHOKE  = 8'd1;
    localparam logic [7:0] ID_INTEREST = 8'd2;
    localparam logic [7:0] ID_NOTINT   = 8'd3;
    localparam logic [7:0] ID_HAVE     = 8'd4;
    localparam logic [7:0] ID_BITFIELD = 8'd5;
    localparam logic [7:0] ID_REQUEST  = 8'd6;
    localparam logic [7:0] ID_PIECE    = 8'd7;
    localparam logic [7:0] ID_CANCEL   = 8'd8;

    // one accepted item on its way to the bitmap stage
    typedef struct packed {
        logic              res;
        logic              query;
        ev_t               ev;
        logic [31:0]       idx;
        logic [31:0]       beg;
        logic [31:0]       len;
        logic [7:0]        pb;
        logic              last;
        logic              resel;
        logic              chok;
        logic              intr;
        logic              q_inrange;
        logic [2:0]        bit_sel;
        logic [ADDR_W-1:0] rd_addr;
        logic              have_wr;
        logic              bf_wr;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        bf_data;
    } item_t;

    typedef struct packed {
        ev_t         ev;
        logic [31:0] idx;
        logic [31:0] beg;
        logic [31:0] len;
        logic [7:0]  pb;
        logic        last;
        logic        resel;
        logic        chok;
        logic        intr;
        logic        has;
    } out_t;

endpackage
`default_nettype wire

// ===== rtl/pwmp_ram.sv =====
`default_nettype none
module pwmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pwmp_frame.sv =====
`default_nettype none
module pwmp_frame
    import pwmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        acc,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [11:0] query_piece,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [43:0] cfg_data,
    output item_t            item
);

    phase_t      phase_reg, phase_next;
    logic [31:0] ml_reg, ml_next;
    logic [31:0] bp_reg, bp_next;
    logic [7:0]  id_reg, id_next;
    logic [31:0] fidx_reg, fidx_next;
    logic [31:0] fbeg_reg, fbeg_next;
    logic [31:0] flen_reg, flen_next;
    logic        chok_reg, chok_next;
    logic        intr_reg, intr_next;
    logic [12:0] count_reg;
    logic [31:0] size_reg;
    logic [43:0] content_reg;
    logic [63:0] prod_reg;
    logic [63:0] pb_reg;

    logic [12:0] eff;
    logic [9:0]  ceil_bytes;
    logic        fits;
    logic        fin;
    logic        range_ok;
    logic [63:0] end_pos;
    logic [31:0] pm1;
    logic [12:0] vbits;

    assign eff        = (count_reg > 13'(MAX_PIECES)) ? 13'(MAX_PIECES) : count_reg;
    assign ceil_bytes = 10'((eff + 13'd7) >> 3);
    assign fits       = (ml_reg == 32'(ceil_bytes) + 32'd1);
    assign end_pos    = pb_reg + {32'd0, flen_next};
    assign range_ok   = (fidx_next < 32'(eff)) && (flen_next != 32'd0)
                        && (end_pos <= {20'd0, content_reg});
    assign pm1        = bp_reg - 32'd1;
    assign vbits      = eff - (13'(pm1[ADDR_W-1:0]) << 3);

    always_comb
    begin
        phase_next = phase_reg;
        ml_next    = ml_reg;
        bp_next    = bp_reg;
        id_next    = id_reg;
        fidx_next  = fidx_reg;
        fbeg_next  = fbeg_reg;
        flen_next  = flen_reg;
        chok_next  = chok_reg;
        intr_next  = intr_reg;
        fin        = 1'b0;
        item       = '0;
        item.rd_addr = query_piece[ADDR_W+2:3];

        if (op)
        begin
            item.res       = 1'b1;
            item.query     = 1'b1;
            item.ev        = EV_QUERY;
            item.q_inrange = 13'(query_piece) < eff;
            item.bit_sel   = query_piece[2:0];
        end
        else
        begin
            case (phase_reg)
                PH_ID:
                begin
                    id_next   = rx_byte;
                    fidx_next = '0;
                    fbeg_next = '0;
                    flen_next = '0;
                    bp_next   = 32'd1;
                    if (ml_reg == 32'd1)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    if (bp_reg >= 32'd1 && bp_reg <= 32'd4)
                    begin
                        fidx_next = {fidx_reg[23:0], rx_byte};
                    end
                    else if (bp_reg >= 32'd5 && bp_reg <= 32'd8)
                    begin
                        fbeg_next = {fbeg_reg[23:0], rx_byte};
                    end
                    else if (bp_reg >= 32'd9 && bp_reg <= 32'd12 && id_reg != ID_PIECE)
                    begin
                        flen_next = {flen_reg[23:0], rx_byte};
                    end

                    if (id_reg == ID_BITFIELD && fits)
                    begin
                        item.bf_wr   = 1'b1;
                        item.wr_addr = pm1[ADDR_W-1:0];
                        if (vbits >= 13'd8)
                        begin
                            item.bf_data = rx_byte;
                        end
                        else
                        begin
                            item.bf_data = rx_byte & 8'(8'hFF << (4'd8 - vbits[3:0]));
                        end
                    end

                    bp_next = bp_reg + 32'd1;
                    if (id_reg == ID_PIECE && bp_reg >= 32'd9)
                    begin
                        item.res  = 1'b1;
                        item.ev   = EV_PIECEDATA;
                        item.idx  = fidx_next;
                        item.beg  = fbeg_next;
                        item.len  = ml_reg - 32'd9;
                        item.pb   = rx_byte;
                        item.last = (bp_next == ml_reg);
                    end
                    if (bp_next == ml_reg)
                    begin
                        fin        = !item.res;
                        phase_next = PH_LEN;
                        ml_next    = '0;
                        bp_next    = '0;
                    end
                end
                default:
                begin
                    ml_next    = {ml_reg[23:0], rx_byte};
                    bp_next    = {30'd0, 2'(bp_reg[1:0] + 2'd1)};
                    phase_next = PH_LEN;
                    if (bp_next == 32'd0)
                    begin
                        if (ml_next == 32'd0)
                        begin
                            item.res = 1'b1;
                            item.ev  = EV_KEEPALIVE;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                end
            endcase
        end

        if (fin)
        begin
            phase_next = PH_LEN;
            ml_next    = '0;
            bp_next    = '0;
            item.res   = 1'b1;
            item.idx   = fidx_next;
            item.beg   = fbeg_next;
            item.len   = flen_next;
            case (id_next)
                ID_CHOKE:
                begin
                    item.resel = !chok_reg;
                    chok_next  = 1'b1;
                    item.ev    = EV_CHOKE;
                end
                ID_UNCHOKE:
                begin
                    chok_next = 1'b0;
                    item.ev   = EV_UNCHOKE;
                end
                ID_INTEREST:
                begin
                    intr_next = 1'b1;
                    item.ev   = EV_INTEREST;
                end
                ID_NOTINT:
                begin
                    intr_next = 1'b0;
                    item.ev   = EV_NOTINT;
                end
                ID_HAVE:
                begin
                    if (ml_reg < 32'd5 || fidx_next >= 32'(eff))
                    begin
                        item.ev = EV_ERROR;
                    end
                    else
                    begin
                        item.ev      = EV_HAVE;
                        item.have_wr = 1'b1;
                        item.rd_addr = fidx_next[ADDR_W+2:3];
                        item.wr_addr = fidx_next[ADDR_W+2:3];
                        item.bit_sel = fidx_next[2:0];
                    end
                end
                ID_BITFIELD:
                begin
                    item.ev = fits ? EV_BITFIELD : EV_BF_SIZE;
                end
                ID_REQUEST, ID_CANCEL:
                begin
                    if (ml_reg < 32'd13 || !range_ok)
                    begin
                        item.ev = EV_ERROR;
                    end
                    else
                    begin
                        item.ev = (id_next == ID_REQUEST) ? EV_REQUEST : EV_CANCEL;
                    end
                end
                ID_PIECE:
                begin
                    // a piece with no data bytes ends silently
                    if (ml_reg >= 32'd9)
                    begin
                        item.res = 1'b0;
                    end
                    else
                    begin
                        item.ev = EV_ERROR;
                    end
                end
                default:
                begin
                    item.ev = EV_UNKNOWN;
                end
            endcase
        end

        item.chok = chok_next;
        item.intr = intr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            ml_reg      <= '0;
            bp_reg      <= '0;
            id_reg      <= '0;
            fidx_reg    <= '0;
            fbeg_reg    <= '0;
            flen_reg    <= '0;
            chok_reg    <= 1'b1;
            intr_reg    <= 1'b0;
            count_reg   <= '0;
            size_reg    <= 32'd262144;
            content_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg <= phase_next;
                ml_reg    <= ml_next;
                bp_reg    <= bp_next;
                id_reg    <= id_next;
                fidx_reg  <= fidx_next;
                fbeg_reg  <= fbeg_next;
                flen_reg  <= flen_next;
                chok_reg  <= chok_next;
                intr_reg  <= intr_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PIECE_COUNT:   count_reg   <= cfg_data[12:0];
                    CFG_PIECE_SIZE:    size_reg    <= cfg_data[31:0];
                    CFG_CONTENT_BYTES: content_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // index settles by byte 4 and begin by byte 8; the range end is needed at byte 12
    always_ff @(posedge clk)
    begin
        prod_reg <= fidx_reg * size_reg;
        pb_reg   <= prod_reg + {32'd0, fbeg_reg};
    end

endmodule
`default_nettype wire

// ===== rtl/pwmp_outq.sv =====
`default_nettype none
module pwmp_outq
    import pwmp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire out_t       din,
    input  wire logic       pop,
    output logic            not_empty,
    output out_t            dout,
    output logic [1:0]      count
);

    out_t       q [QDEPTH];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != 2'd0);
    assign dout      = q[rp_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        wp_next  = push ? ((wp_reg == 2'(QDEPTH - 1)) ? 2'd0 : 2'(wp_reg + 2'd1)) : wp_reg;
        rp_next  = pop  ? ((rp_reg == 2'(QDEPTH - 1)) ? 2'd0 : 2'(rp_reg + 2'd1)) : rp_reg;
        cnt_next = 2'(cnt_reg + 2'(push) - 2'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wp_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/peer_wire_message_parser_core.sv =====
// Peer-wire message parser.
// Input channel (in_valid / in_stall): one transfer per received stream byte
// (op = 0) or per bitmap query (op = 1, query_piece). Queries do not disturb
// message framing.
// Output channel (out_valid / out_stall): at most one result per input
// transfer, in input order. Piece data bytes come out one per transfer with
// last_of_block on the final byte.
// A result is registered in the bitmap stage, then in the output buffer.
// Throughput: one input transfer per cycle while in_stall is low; the
// have-bitmap read-modify-write in the second stage is forwarded to the next
// read. Reset: the 512-byte have-bitmap is cleared by a sweep, one entry per
// cycle; in_stall is high for that time. Config writes are taken at any time
// through cfg_we / cfg_index / cfg_data. Back-pressure: results queue in a
// three-entry output buffer; in_stall rises during the bitmap clear and when
// that buffer plus the item in flight could overflow.
`default_nettype none
module peer_wire_message_parser_core
    import pwmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [11:0] query_piece,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       event_res,
    output logic [31:0]      piece_index,
    output logic [31:0]      block_begin,
    output logic [31:0]      block_length,
    output logic [7:0]       payload_byte,
    output logic             last_of_block,
    output logic             reselect_needed,
    output logic             peer_choking_now,
    output logic             peer_interested_now,
    output logic             has_piece,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [43:0] cfg_data
);

    logic              acc;
    item_t             item;
    item_t             s1_reg;
    logic              s1_v_reg;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]        rdata;
    logic [7:0]        cur;
    logic              fwd_v_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_data_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              s1_wr;
    out_t              s1_out;
    out_t              q_out;
    logic              push;
    logic              pop;
    logic [1:0]        q_count;

    assign in_stall = clr_active_reg
                      || ((3'(q_count) + 3'(s1_v_reg)) >= 3'(QDEPTH));
    assign acc      = in_valid && !in_stall;

    pwmp_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .op          (op),
        .rx_byte     (rx_byte),
        .query_piece (query_piece),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item)
    );

    // bitmap stage: forward the write made at the edge that issued this read
    assign cur = (fwd_v_reg && fwd_addr_reg == s1_reg.rd_addr) ? fwd_data_reg : rdata;
    assign s1_wr = s1_v_reg && (s1_reg.have_wr || s1_reg.bf_wr);

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_wr;
            ram_waddr = s1_reg.wr_addr;
            ram_wdata = s1_reg.have_wr ? (cur | (8'h80 >> s1_reg.bit_sel)) : s1_reg.bf_data;
        end
    end

    pwmp_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (item.rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_out.ev    = s1_reg.ev;
        s1_out.idx   = s1_reg.idx;
        s1_out.beg   = s1_reg.beg;
        s1_out.len   = s1_reg.len;
        s1_out.pb    = s1_reg.pb;
        s1_out.last  = s1_reg.last;
        s1_out.resel = s1_reg.resel;
        s1_out.chok  = s1_reg.chok;
        s1_out.intr  = s1_reg.intr;
        s1_out.has   = s1_reg.query && s1_reg.q_inrange && cur[3'd7 - s1_reg.bit_sel];
    end

    assign push = s1_v_reg && s1_reg.res;
    assign pop  = out_valid && !out_stall;

    pwmp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (s1_out),
        .pop       (pop),
        .not_empty (out_valid),
        .dout      (q_out),
        .count     (q_count)
    );

    assign event_res           = q_out.ev;
    assign piece_index         = q_out.idx;
    assign block_begin         = q_out.beg;
    assign block_length        = q_out.len;
    assign payload_byte        = q_out.pb;
    assign last_of_block       = q_out.last;
    assign reselect_needed     = q_out.resel;
    assign peer_choking_now    = q_out.chok;
    assign peer_interested_now = q_out.intr;
    assign has_piece           = q_out.has;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            fwd_v_reg      <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            s1_v_reg  <= acc;
            fwd_v_reg <= s1_wr && !clr_active_reg;
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAP_BYTES - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= item;
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> !clr_active_reg)
        else $error("transfer accepted during bitmap clear");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (3'(q_count) + 3'(s1_v_reg)) <= 3'(QDEPTH))
        else $error("output buffer may overflow");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("bitmap clear restarted");

    a_one_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> !(s1_reg.have_wr && s1_reg.bf_wr))
        else $error("have and bitfield write in one item");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb
    import pwmp_pkg::*;
();

    typedef struct packed {
        logic [3:0]  ev;
        logic [31:0] idx;
        logic [31:0] beg;
        logic [31:0] len;
        logic [7:0]  pb;
        logic        last;
        logic        resel;
        logic        chok;
        logic        intr;
        logic        has;
    } result_t;

    // Parser model plus queue of predicted results.
    class parser_scoreboard;
        logic [12:0] cnt_reg;
        logic [31:0] psize;
        logic [43:0] content;
        phase_t      phase;
        logic [31:0] mlen;
        logic [31:0] bpos;
        logic [7:0]  mid;
        logic [31:0] f_idx;
        logic [31:0] f_beg;
        logic [31:0] f_len;
        logic        choking;
        logic        interested;
        logic [7:0]  bitmap [MAP_BYTES];
        result_t     pending [$];
        int          errors;

        function new();
            cnt_reg = 0;
            psize = 32'd262144;
            content = 0;
            phase = PH_LEN;
            mlen = 0;
            bpos = 0;
            mid = 0;
            f_idx = 0;
            f_beg = 0;
            f_len = 0;
            choking = 1;
            interested = 0;
            errors = 0;
            foreach (bitmap[k]) bitmap[k] = 8'h00;
        endfunction

        function void set_reg(logic [1:0] idx, logic [43:0] val);
            if (idx == CFG_PIECE_COUNT) cnt_reg = val[12:0];
            else if (idx == CFG_PIECE_SIZE) psize = val[31:0];
            else if (idx == CFG_CONTENT_BYTES) content = val;
        endfunction

        function logic [31:0] count_eff();
            return (cnt_reg > MAX_PIECES) ? MAX_PIECES : {19'd0, cnt_reg};
        endfunction

        function logic bitfield_fits();
            logic [32:0] need;
            need = (count_eff() + 7) / 8;
            return ({1'b0, mlen} - 33'd1) == need;
        endfunction

        function result_t make(logic [3:0] ev, logic [31:0] blen, logic [7:0] pb,
                               logic last, logic resel);
            result_t r;
            r.ev = ev;
            r.idx = f_idx;
            r.beg = f_beg;
            r.len = blen;
            r.pb = pb;
            r.last = last;
            r.resel = resel;
            r.chok = choking;
            r.intr = interested;
            r.has = 0;
            return r;
        endfunction

        function logic range_ok();
            logic [95:0] stop;
            if (f_idx >= count_eff() || f_len == 0) return 0;
            stop = 96'(f_idx) * 96'(psize) + 96'(f_beg) + 96'(f_len);
            return stop <= 96'(content);
        endfunction

        function bit close_message(output result_t r);
            logic resel;
            ev_t  ev;
            resel = 0;
            case (mid)
                ID_CHOKE:
                begin
                    resel = !choking;
                    choking = 1;
                    ev = EV_CHOKE;
                end
                ID_UNCHOKE:
                begin
                    choking = 0;
                    ev = EV_UNCHOKE;
                end
                ID_INTEREST:
                begin
                    interested = 1;
                    ev = EV_INTEREST;
                end
                ID_NOTINT:
                begin
                    interested = 0;
                    ev = EV_NOTINT;
                end
                ID_HAVE:
                begin
                    if (mlen < 5 || f_idx >= count_eff()) ev = EV_ERROR;
                    else
                    begin
                        bitmap[f_idx[11:3]] |= 8'h80 >> f_idx[2:0];
                        ev = EV_HAVE;
                    end
                end
                ID_BITFIELD: ev = bitfield_fits() ? EV_BITFIELD : EV_BF_SIZE;
                ID_REQUEST, ID_CANCEL:
                begin
                    if (mlen < 13 || !range_ok()) ev = EV_ERROR;
                    else ev = (mid == ID_REQUEST) ? EV_REQUEST : EV_CANCEL;
                end
                ID_PIECE:
                begin
                    if (mlen >= 9) return 0;
                    ev = EV_ERROR;
                end
                default: ev = EV_UNKNOWN;
            endcase
            r = make(ev, f_len, 8'd0, 1'b0, resel);
            return 1;
        endfunction

        function void note_input(logic opq, logic [7:0] b, logic [11:0] q);
            result_t r;
            logic [31:0] p;
            logic [31:0] v;
            logic [7:0] mask;
            bit got;
            got = 0;
            if (opq)
            begin
                r = '0;
                r.ev = EV_QUERY;
                r.chok = choking;
                r.intr = interested;
                r.has = (q < count_eff()) ? bitmap[q[11:3]][7 - q[2:0]] : 1'b0;
                pending.push_back(r);
                return;
            end
            if (phase == PH_ID)
            begin
                mid = b;
                f_idx = 0;
                f_beg = 0;
                f_len = 0;
                bpos = 1;
                if (mlen == 1)
                begin
                    got = close_message(r);
                    phase = PH_LEN;
                    mlen = 0;
                    bpos = 0;
                end
                else phase = PH_PAY;
            end
            else if (phase == PH_PAY)
            begin
                p = bpos;
                if (p >= 1 && p <= 4) f_idx = {f_idx[23:0], b};
                else if (p >= 5 && p <= 8) f_beg = {f_beg[23:0], b};
                else if (p >= 9 && p <= 12 && mid != ID_PIECE) f_len = {f_len[23:0], b};
                if (mid == ID_BITFIELD && bitfield_fits())
                begin
                    v = count_eff() - 8 * (p - 1);
                    mask = (v >= 8) ? 8'hFF : 8'(8'hFF << (8 - v));
                    bitmap[(p - 1) % MAP_BYTES] = b & mask;
                end
                bpos = p + 1;
                if (mid == ID_PIECE && p >= 9)
                begin
                    r = make(EV_PIECEDATA, mlen - 9, b, bpos == mlen, 1'b0);
                    got = 1;
                end
                if (bpos == mlen)
                begin
                    if (!got) got = close_message(r);
                    phase = PH_LEN;
                    mlen = 0;
                    bpos = 0;
                end
            end
            else
            begin
                mlen = {mlen[23:0], b};
                bpos = (bpos + 1) & 3;
                phase = PH_LEN;
                if (bpos == 0)
                begin
                    if (mlen == 0)
                    begin
                        r = '0;
                        r.ev = EV_KEEPALIVE;
                        r.chok = choking;
                        r.intr = interested;
                        got = 1;
                    end
                    else phase = PH_ID;
                end
            end
            if (got) pending.push_back(r);
        endfunction

        function void check_result(result_t act);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r !== act)
            begin
                $display("%0t: expected %h actual %h", $time, exp_r, act);
                $display("  ev %0d/%0d idx %h/%h beg %h/%h len %h/%h pb %h/%h",
                         exp_r.ev, act.ev, exp_r.idx, act.idx, exp_r.beg, act.beg,
                         exp_r.len, act.len, exp_r.pb, act.pb);
                $display("  last %b/%b resel %b/%b chok %b/%b intr %b/%b has %b/%b",
                         exp_r.last, act.last, exp_r.resel, act.resel, exp_r.chok,
                         act.chok, exp_r.intr, act.intr, exp_r.has, act.has);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  rx_byte;
    logic [11:0] query_piece;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  event_res;
    logic [31:0] piece_index;
    logic [31:0] block_begin;
    logic [31:0] block_length;
    logic [7:0]  payload_byte;
    logic        last_of_block;
    logic        reselect_needed;
    logic        peer_choking_now;
    logic        peer_interested_now;
    logic        has_piece;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [43:0] cfg_data;

    peer_wire_message_parser_core i_dut (.*);

    parser_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int items_sent;
    logic [7:0] msg [$];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({event_res, piece_index, block_begin, block_length,
                                 payload_byte, last_of_block, reselect_needed,
                                 peer_choking_now, peer_interested_now, has_piece});
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000)
            begin
                $display("peer_wire_message_parser_core: mismatch");
                $finish;
            end
        end
    end

    // valid stays up after a transfer; the next idle cycle or drain drops it
    task automatic send_item(logic opq, logic [7:0] b, logic [11:0] q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= opq;
        rx_byte <= b;
        query_piece <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(opq, b, q);
        items_sent++;
    endtask

    task automatic send_msg();
        logic [31:0] n;
        n = msg.size();
        for (int k = 3; k >= 0; k--) send_item(1'b0, n[8*k +: 8], 12'd0);
        foreach (msg[k])
        begin
            if ($urandom_range(15) == 0) send_item(1'b1, 8'($urandom), 12'($urandom));
            send_item(1'b0, msg[k], 12'd0);
        end
        msg.delete();
    endtask

    task automatic push32(logic [31:0] v);
        for (int k = 3; k >= 0; k--) msg.push_back(v[8*k +: 8]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [43:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_index(logic [31:0] cnt);
        case ($urandom_range(5))
            0: return $urandom;
            1: return cnt;
            2: return (cnt == 0) ? 0 : cnt - 1;
            default: return (cnt == 0) ? 0 : $urandom_range(cnt - 1);
        endcase
    endfunction

    task automatic random_msg();
        logic [31:0] cnt;
        int nbytes;
        int extra;
        cnt = sb.count_eff();
        extra = ($urandom_range(7) == 0) ? $urandom_range(3) : 0;
        case ($urandom_range(11))
            0, 1:
            begin
                msg.push_back(8'($urandom_range(3)));
                repeat (extra) msg.push_back(8'($urandom));
            end
            2, 3:
            begin
                msg.push_back(ID_HAVE);
                push32(pick_index(cnt));
                repeat (extra) msg.push_back(8'($urandom));
                if ($urandom_range(9) == 0) msg.pop_back();
            end
            4:
            begin
                msg.push_back(ID_BITFIELD);
                nbytes = (cnt + 7) / 8;
                if (nbytes > 24 || $urandom_range(5) == 0) nbytes = $urandom_range(4);
                repeat (nbytes) msg.push_back(8'($urandom));
            end
            5, 6, 7:
            begin
                msg.push_back(($urandom_range(1) == 0) ? ID_REQUEST : ID_CANCEL);
                push32(pick_index(cnt));
                push32($urandom_range(3) == 0 ? $urandom : $urandom_range(4096));
                push32($urandom_range(5) == 0 ? 32'd0 :
                       ($urandom_range(3) == 0 ? $urandom : $urandom_range(1, 16384)));
                repeat (extra) msg.push_back(8'($urandom));
                if ($urandom_range(9) == 0) repeat ($urandom_range(1, 5)) msg.pop_back();
            end
            8, 9:
            begin
                msg.push_back(ID_PIECE);
                push32($urandom);
                push32($urandom);
                repeat ($urandom_range(0, 12)) msg.push_back(8'($urandom));
                if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) msg.pop_back();
            end
            10: msg.push_back(8'($urandom_range(9, 255)));
            default:
            begin
                // keepalive: empty message
            end
        endcase
        send_msg();
        if ($urandom_range(15) == 0) send_item(1'b1, 8'($urandom), 12'(pick_index(cnt)));
    endtask

    initial
    begin
        int phase_no;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        op = 0;
        rx_byte = 0;
        query_piece = 0;
        cfg_we = 0;
        cfg_index = CFG_PIECE_COUNT;
        cfg_data = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults first (count 0), then small settings
        send_item(1'b1, 8'hFF, 12'hFFF);
        send_msg();
        msg.push_back(ID_UNCHOKE); send_msg();
        msg.push_back(ID_CHOKE); send_msg();
        msg.push_back(ID_CHOKE); send_msg();
        drain();
        write_reg(CFG_PIECE_COUNT, 44'd10);
        write_reg(CFG_PIECE_SIZE, 44'd16);
        write_reg(CFG_CONTENT_BYTES, 44'd160);
        msg.push_back(ID_INTEREST); send_msg();
        msg.push_back(ID_BITFIELD); msg.push_back(8'hFF); msg.push_back(8'hFF); send_msg();
        send_item(1'b1, 8'h00, 12'd9);
        send_item(1'b1, 8'h00, 12'd10);
        msg.push_back(ID_HAVE); push32(32'd10); send_msg();
        msg.push_back(ID_REQUEST); push32(32'd9); push32(32'd0); push32(32'd16); send_msg();
        msg.push_back(ID_CANCEL); push32(32'd9); push32(32'd1); push32(32'd16); send_msg();
        msg.push_back(ID_PIECE); push32(32'hFFFFFFFF); push32(32'h0); send_msg();
        msg.push_back(ID_PIECE); push32(32'd1); push32(32'd2);
        msg.push_back(8'h00); msg.push_back(8'hFF); send_msg();
        msg.push_back(8'hFF); send_msg();
        drain();

        for (phase_no = 0; phase_no < 8; phase_no++)
        begin
            case (phase_no % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 54; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 54; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            case (phase_no)
                0: write_reg(CFG_PIECE_COUNT, 44'd13);
                3: write_reg(CFG_PIECE_COUNT, 44'h1FFF);
                5: write_reg(CFG_PIECE_COUNT, 44'd4096);
                6: write_reg(CFG_PIECE_COUNT, 44'd0);
                default: write_reg(CFG_PIECE_COUNT, 44'($urandom_range(1, 100)));
            endcase
            case (phase_no % 3)
                0: write_reg(CFG_PIECE_SIZE, 44'd1);
                1: write_reg(CFG_PIECE_SIZE, 44'hFFFFFFFF);
                default: write_reg(CFG_PIECE_SIZE, 44'($urandom_range(1, 65536)));
            endcase
            case (phase_no % 4)
                0: write_reg(CFG_CONTENT_BYTES, 44'hFFFFFFFFFFF);
                1: write_reg(CFG_CONTENT_BYTES, 44'd0);
                default: write_reg(CFG_CONTENT_BYTES, {12'($urandom), 32'($urandom)} >>
                                   $urandom_range(0, 30));
            endcase
            while (items_sent < 114 * (phase_no + 1) + 40) random_msg();
            drain();
        end

        if (sb.errors == 0)
            $display("peer_wire_message_parser_core: match");
        else
            $display("peer_wire_message_parser_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
